/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers for the link table
// clocked concurrent checks, with and without the reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check held off while rst is high
`define SCLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs across reset
`define SCLT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/sclt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_pkg: shared types and constants of the scene link table
// table geometry, function and status codes, controller/datapath interface
// ----------------------------------------------------------------------------
package sclt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] FN_ADD       = 4'd0;
  localparam logic [3:0] FN_REMOVE    = 4'd1;
  localparam logic [3:0] FN_ANY_CONS  = 4'd2;
  localparam logic [3:0] FN_ANY_PROV  = 4'd3;
  localparam logic [3:0] FN_LOOKUP    = 4'd4;
  localparam logic [3:0] FN_HAS_CONS  = 4'd5;
  localparam logic [3:0] FN_LIST_CONS = 4'd6;
  localparam logic [3:0] FN_LIST_PROV = 4'd7;
  localparam logic [3:0] FN_LIST_PKEY = 4'd8;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_MISS = 2'd3
  } sts_code_t;

  typedef enum logic [1:0] {
    M_CKEY,
    M_CSCENE,
    M_PSCENE,
    M_PKEY
  } mode_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RAM,
    SRC_REQ,
    SRC_PEND
  } src_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef struct packed {
    logic [31:0] p_scene;
    logic [15:0] p_slot;
    logic [31:0] c_scene;
    logic [15:0] c_slot;
  } entry_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      pend_load;
    logic      append;
    logic      mark_hit;
    logic      shift_rd;
    logic      shift_wr;
    logic      dec;
    logic      emit;
    src_t      emit_src;
    sts_code_t emit_status;
    logic      emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       hit;
    logic       scan_end;
    logic       full;
    logic       pend_valid;
    logic       shift_end;
  } dp_sts_t;

  function automatic mode_t func_mode(input logic [3:0] f);
    mode_t m;
    case (f)
      FN_ANY_CONS, FN_LIST_CONS: m = M_CSCENE;
      FN_ANY_PROV, FN_LIST_PROV: m = M_PSCENE;
      FN_HAS_CONS, FN_LIST_PKEY: m = M_PKEY;
      default:                   m = M_CKEY;
    endcase
    return m;
  endfunction

  function automatic logic entry_match(input mode_t m, input entry_t e, input entry_t r);
    logic hit;
    case (m)
      M_CKEY:   hit = (e.c_scene == r.c_scene) && (e.c_slot == r.c_slot);
      M_CSCENE: hit = e.c_scene == r.c_scene;
      M_PSCENE: hit = e.p_scene == r.p_scene;
      M_PKEY:   hit = (e.p_scene == r.p_scene) && (e.p_slot == r.p_slot);
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* src/sclt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sclt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sclt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_dp: link table datapath
// request registers, link memory, scan and shift counters, result registers
// ----------------------------------------------------------------------------
module sclt_dp
  import sclt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts,
  input  logic [3:0]  func,
  input  logic [31:0] provider_scene,
  input  logic [15:0] provider_slot,
  input  logic [31:0] consumer_scene,
  input  logic [15:0] consumer_slot,
  output logic        result_valid,
  output logic        found,
  output logic [31:0] link_provider_scene,
  output logic [15:0] link_provider_slot,
  output logic [31:0] link_consumer_scene,
  output logic [15:0] link_consumer_slot,
  output logic [1:0]  status,
  output logic        last
);

  logic [3:0]       func_q;
  entry_t           req;
  entry_t           pend;
  logic             pend_valid;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic [IDX_W-1:0] shift_idx;
  logic             rd_more;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  entry_t           sel;

  assign rd_more = rd_idx < count;

  assign ram_we    = cmd.append | cmd.shift_wr;
  assign ram_waddr = cmd.append ? count[IDX_W-1:0] : shift_idx;
  assign ram_wdata = cmd.append ? req : ram_rdata;
  assign ram_raddr = cmd.shift_rd ? IDX_W'(shift_idx + 1'b1) : rd_idx[IDX_W-1:0];

  sclt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    sts.func       = func_q;
    sts.hit        = chk_valid && entry_match(func_mode(func_q), ram_rdata, req);
    sts.scan_end   = !chk_valid && !rd_more;
    sts.full       = count == CNT_W'(TABLE_DEPTH);
    sts.pend_valid = pend_valid;
    sts.shift_end  = (CNT_W'(shift_idx) + CNT_W'(1)) >= count;
  end

  always_comb begin
    case (cmd.emit_src)
      SRC_RAM:  sel = ram_rdata;
      SRC_REQ:  sel = req;
      SRC_PEND: sel = pend;
      default:  sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      chk_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.load) begin
        chk_valid  <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        chk_valid <= cmd.scan && rd_more;
        if (cmd.pend_load) begin
          pend_valid <= 1'b1;
        end
      end
      if (cmd.append) begin
        count <= count + 1'b1;
      end else if (cmd.dec) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      req    <= '{p_scene: provider_scene, p_slot: provider_slot,
                  c_scene: consumer_scene, c_slot: consumer_slot};
      rd_idx <= '0;
    end else if (cmd.scan && rd_more) begin
      rd_idx  <= rd_idx + 1'b1;
      chk_idx <= rd_idx[IDX_W-1:0];
    end
    if (cmd.pend_load) begin
      pend <= ram_rdata;
    end
    if (cmd.mark_hit) begin
      shift_idx <= chk_idx;
    end else if (cmd.shift_wr) begin
      shift_idx <= shift_idx + 1'b1;
    end
    if (cmd.emit) begin
      found               <= cmd.emit_src != SRC_NONE;
      link_provider_scene <= sel.p_scene;
      link_provider_slot  <= sel.p_slot;
      link_consumer_scene <= sel.c_scene;
      link_consumer_slot  <= sel.c_slot;
      status              <= cmd.emit_status;
      last                <= cmd.emit_last;
    end
  end

endmodule

/* src/sclt_ctl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_ctl: link table controller
// sequences the scan, append, removal shift and result transfers
// ----------------------------------------------------------------------------
module sclt_ctl
  import sclt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_src    = SRC_NONE;
    cmd.emit_status = STS_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.func inside {FN_LIST_CONS, FN_LIST_PROV, FN_LIST_PKEY}) begin
          if (sts.hit) begin
            cmd.pend_load = 1'b1;
            cmd.emit      = sts.pend_valid;
            cmd.emit_src  = SRC_PEND;
          end else if (sts.scan_end) begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = sts.pend_valid ? SRC_PEND : SRC_NONE;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (sts.func inside {[FN_ADD:FN_HAS_CONS]}) begin
          if (sts.hit) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = SRC_RAM;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = (sts.func == FN_ADD) ? STS_DUP : STS_OK;
            if (sts.func == FN_REMOVE) begin
              cmd.mark_hit = 1'b1;
              state_next   = S_SHIFT_RD;
            end else begin
              state_next = S_IDLE;
            end
          end else if (sts.scan_end) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
            if (sts.func == FN_ADD) begin
              if (sts.full) begin
                cmd.emit_status = STS_FULL;
              end else begin
                cmd.append   = 1'b1;
                cmd.emit_src = SRC_REQ;
              end
            end else if (sts.func == FN_REMOVE || sts.func == FN_LOOKUP) begin
              cmd.emit_status = STS_MISS;
            end
          end
        end else begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_end) begin
          cmd.dec    = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/scene_link_table_top.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// scene_link_table_top: ordered table of provider/consumer slot links
//
// channel   handshake              payload
// command   start, busy            func, provider_scene, provider_slot,
//                                  consumer_scene, consumer_slot
// result    result_valid (strobe)  found, link_*, status, last
//
// the link memory is scanned one entry per cycle; a list gives at most one result
// transfer per cycle; a remove then shifts the later entries down, reading and then
// writing each moved entry; reset empties the table; except after a remove, busy
// falls as the final result is registered, so the final transfer overlaps the first
// idle cycle
// results are single-cycle strobes, the receiver cannot stall them
// ----------------------------------------------------------------------------
module scene_link_table_top
  import sclt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [31:0] provider_scene,
  input  logic [15:0] provider_slot,
  input  logic [31:0] consumer_scene,
  input  logic [15:0] consumer_slot,
  output logic        result_valid,
  output logic        found,
  output logic [31:0] link_provider_scene,
  output logic [15:0] link_provider_slot,
  output logic [31:0] link_consumer_scene,
  output logic [15:0] link_consumer_slot,
  output logic [1:0]  status,
  output logic        last
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     link_zero;

  sclt_ctl u_ctl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  sclt_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .func               (func),
    .provider_scene     (provider_scene),
    .provider_slot      (provider_slot),
    .consumer_scene     (consumer_scene),
    .consumer_slot      (consumer_slot),
    .result_valid       (result_valid),
    .found              (found),
    .link_provider_scene(link_provider_scene),
    .link_provider_slot (link_provider_slot),
    .link_consumer_scene(link_consumer_scene),
    .link_consumer_slot (link_consumer_slot),
    .status             (status),
    .last               (last)
  );

  assign link_zero = (link_provider_scene == '0) && (link_provider_slot == '0)
                     && (link_consumer_scene == '0) && (link_consumer_slot == '0);

  `SCLT_ASSERT_RST(a_reset_quiet, rst |=> !result_valid && !busy, "results or busy after reset")
  `SCLT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted command did not raise busy")
  `SCLT_ASSERT(a_more_busy, result_valid && !last |-> busy, "non-final transfer while idle")
  `SCLT_ASSERT(a_miss_zero, result_valid && !found |-> link_zero, "miss transfer carries link data")

endmodule
